// ----- rtl/core/modular_arithmetic_unit_top_assert.svh -----
// Assertion macros for the modular arithmetic unit checker.
`ifndef MODULAR_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define MAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- rtl/core/mau_pkg.sv -----
// Package: types, constants and state encoding of the modular arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package mau_pkg;
	localparam int unsigned MODULUS_BITS = 62;
	localparam logic [61:0] MODULUS_RESET = 62'd998244353;

	typedef enum logic [2:0] {
		OP_REDUCE = 3'd0,
		OP_ADD    = 3'd1,
		OP_SUB    = 3'd2,
		OP_MUL    = 3'd3,
		OP_POW    = 3'd4,
		OP_INV    = 3'd5,
		OP_DIV    = 3'd6,
		OP_NEG    = 3'd7
	} opcode_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [63:0] operand_a;
		logic [63:0] operand_b;
	} in_item_t;

	typedef struct packed {
		logic [61:0] result;
		logic        error;
	} out_item_t;

	// datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,      // latch operands, start reduction of a
		CMD_RED_B,     // start reduction of b
		CMD_ADD,
		CMD_SUB,
		CMD_NEG,
		CMD_MUL_AB,    // start r = a*b
		CMD_MUL_RR,    // start r = r*r
		CMD_MUL_RA,    // start r = r*a
		CMD_MUL_AI,    // start r = a*inv
		CMD_INV_A,     // start Euclid on a
		CMD_INV_B,     // start Euclid on b
		CMD_SET_ONE,
		CMD_SET_ZERO,
		CMD_SET_A
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
	} ctrl_t;

	typedef struct packed {
		logic busy;      // a multi-cycle unit is running
		logic mod_small; // modulus below two
		logic exp_neg;
		logic exp_bit;   // exponent bit at current index
	} stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_A,
		ST_RED_B,
		ST_DISPATCH,
		ST_POW_SQ,
		ST_POW_MUL,
		ST_INV,
		ST_DIV_MUL,
		ST_WAIT,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ----- rtl/core/mau_datapath.sv -----
// Datapath: operand registers, serial reducer, modular multiplier, Euclid unit.
`timescale 1ns / 1ps
`default_nettype none
module mau_datapath #(
	parameter int unsigned MODULUS_BITS = mau_pkg::MODULUS_BITS
) (
	input  wire               clk,
	input  wire               arst_n,
	input  mau_pkg::ctrl_t    ctrl,
	input  mau_pkg::in_item_t item,
	input  wire [61:0]        modulus,
	input  wire [5:0]         exp_idx,
	output mau_pkg::stat_t    stat,
	output logic [61:0]       res
);
	localparam int unsigned MB = MODULUS_BITS;
	// unit selector
	typedef enum logic [1:0] {U_NONE, U_RED, U_MUL, U_INV} unit_t;

	logic [MB-1:0] m_w;
	logic [MB-1:0] a_q, b_q, r_q, inv_q;
	logic [63:0]   rawb_q;
	unit_t         unit_q;
	logic          red_to_b_q;

	// reducer: restoring remainder of a 64-bit magnitude, one bit a cycle
	logic [63:0] red_mag_q;
	logic        red_neg_q;
	logic [MB:0] red_rem_q;
	logic [6:0]  red_cnt_q;
	// multiplier: MSB-first shift and add
	logic [MB-1:0] mx_q, my_q, acc_q;
	logic [6:0]    mcnt_q;
	// Euclid: quotient by shift-subtract, one bit a cycle
	logic [MB-1:0] ea_q, eb_q, er_q, eq_q;
	logic [63:0]   eu_q, ev_q, qv_q, vs_q;
	logic [6:0]    ecnt_q;
	logic [1:0]    ephase_q;

	logic [MB:0] red_sh, red_sub;
	logic [MB:0] dbl, dbl_s, ad, ad_s;
	logic [MB-1:0] dbl_r;
	logic [MB:0] e_sh, e_sub;
	logic [63:0]   inv_mag;
	logic [63:0]   inv_red;
	logic [MB-1:0] inv_fin;
	logic [MB:0]   sum_w, sub_w;

	assign m_w = modulus[MB-1:0];
	assign stat.busy = (unit_q != U_NONE);
	assign stat.mod_small = (modulus < 62'd2);
	assign stat.exp_neg = rawb_q[63];
	assign stat.exp_bit = rawb_q[exp_idx];
	assign res = 62'(r_q);

	assign red_sh  = {red_rem_q[MB-1:0], red_mag_q[63]};
	assign red_sub = red_sh - {1'b0, m_w};
	assign dbl     = {acc_q, 1'b0};
	assign dbl_s   = dbl - {1'b0, m_w};
	assign dbl_r   = (dbl >= {1'b0, m_w}) ? dbl_s[MB-1:0] : acc_q << 1;
	assign ad      = {1'b0, dbl_r} + {1'b0, mx_q};
	assign ad_s    = ad - {1'b0, m_w};
	assign e_sh    = {er_q, ea_q[MB-1]};
	assign e_sub   = e_sh - {1'b0, eb_q};
	assign inv_mag = eu_q[63] ? (64'd0 - eu_q) : eu_q;
	// the final coefficient never exceeds the modulus, so one subtract reduces it
	assign inv_red = (inv_mag >= 64'(m_w)) ? inv_mag - 64'(m_w) : inv_mag;
	assign inv_fin = !eu_q[63] ? inv_red[MB-1:0] :
		(inv_red == 64'd0) ? '0 : m_w - inv_red[MB-1:0];
	assign sum_w   = {1'b0, a_q} + {1'b0, b_q};
	assign sub_w   = {1'b0, a_q} - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= U_NONE;
		end else begin
			case (ctrl.cmd)
				mau_pkg::CMD_LOAD, mau_pkg::CMD_RED_B: unit_q <= U_RED;
				mau_pkg::CMD_MUL_AB, mau_pkg::CMD_MUL_RR,
				mau_pkg::CMD_MUL_RA, mau_pkg::CMD_MUL_AI: unit_q <= U_MUL;
				mau_pkg::CMD_INV_A, mau_pkg::CMD_INV_B: unit_q <= U_INV;
				default: begin
					case (unit_q)
						U_RED: if (red_cnt_q == 7'd0) unit_q <= U_NONE;
						U_MUL: if (mcnt_q == 7'd0) unit_q <= U_NONE;
						U_INV: if (ephase_q == 2'd3) unit_q <= U_NONE;
						default: unit_q <= U_NONE;
					endcase
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			mau_pkg::CMD_LOAD: begin
				rawb_q     <= item.operand_b;
				red_neg_q  <= item.operand_a[63];
				red_mag_q  <= item.operand_a[63] ? 64'd0 - item.operand_a : item.operand_a;
				red_rem_q  <= '0;
				red_cnt_q  <= 7'd64;
				red_to_b_q <= 1'b0;
			end
			mau_pkg::CMD_RED_B: begin
				red_neg_q  <= rawb_q[63];
				red_mag_q  <= rawb_q[63] ? 64'd0 - rawb_q : rawb_q;
				red_rem_q  <= '0;
				red_cnt_q  <= 7'd64;
				red_to_b_q <= 1'b1;
			end
			mau_pkg::CMD_ADD: r_q <= (sum_w >= {1'b0, m_w}) ? MB'(sum_w - {1'b0, m_w})
				: sum_w[MB-1:0];
			mau_pkg::CMD_SUB: r_q <= sub_w[MB] ? MB'(sub_w + {1'b0, m_w}) : sub_w[MB-1:0];
			mau_pkg::CMD_NEG: r_q <= (a_q == '0) ? '0 : m_w - a_q;
			mau_pkg::CMD_SET_ONE: r_q <= MB'(1);
			mau_pkg::CMD_SET_ZERO: r_q <= '0;
			mau_pkg::CMD_SET_A: r_q <= a_q;
			mau_pkg::CMD_MUL_AB: begin mx_q <= a_q; my_q <= b_q; acc_q <= '0;
				mcnt_q <= 7'(MB); end
			mau_pkg::CMD_MUL_RR: begin mx_q <= r_q; my_q <= r_q; acc_q <= '0;
				mcnt_q <= 7'(MB); end
			mau_pkg::CMD_MUL_RA: begin mx_q <= a_q; my_q <= r_q; acc_q <= '0;
				mcnt_q <= 7'(MB); end
			mau_pkg::CMD_MUL_AI: begin mx_q <= a_q; my_q <= inv_q; acc_q <= '0;
				mcnt_q <= 7'(MB); end
			mau_pkg::CMD_INV_A, mau_pkg::CMD_INV_B: begin
				ea_q <= (ctrl.cmd == mau_pkg::CMD_INV_A) ? a_q : b_q;
				eb_q <= m_w;
				eu_q <= 64'd1; ev_q <= 64'd0;
				ephase_q <= 2'd0;
			end
			default: begin
				case (unit_q)
					U_RED: begin
						if (red_cnt_q != 7'd0) begin
							red_rem_q <= red_sub[MB] ? red_sh : red_sub;
							red_mag_q <= {red_mag_q[62:0], 1'b0};
							red_cnt_q <= red_cnt_q - 7'd1;
						end
						if (red_cnt_q == 7'd0) begin
							if (red_to_b_q)
								b_q <= (red_neg_q && red_rem_q != '0) ?
									m_w - red_rem_q[MB-1:0] : red_rem_q[MB-1:0];
							else
								a_q <= (red_neg_q && red_rem_q != '0) ?
									m_w - red_rem_q[MB-1:0] : red_rem_q[MB-1:0];
						end
					end
					U_MUL: begin
						if (mcnt_q != 7'd0) begin
							if (my_q[MB-1])
								acc_q <= ad_s[MB] ? ad[MB-1:0] : ad_s[MB-1:0];
							else
								acc_q <= dbl_r;
							my_q <= my_q << 1;
							mcnt_q <= mcnt_q - 7'd1;
						end else begin
							r_q <= acc_q;
						end
					end
					U_INV: begin
						case (ephase_q)
							2'd0: begin
								// start division ea / eb
								if (eb_q == '0) begin
									ephase_q <= 2'd3;
									inv_q <= inv_fin;
									r_q <= inv_fin;
								end else begin
									er_q <= '0; eq_q <= '0;
									ecnt_q <= 7'(MB);
									ephase_q <= 2'd1;
								end
							end
							2'd1: begin
								if (ecnt_q != 7'd0) begin
									er_q <= e_sub[MB] ? e_sh[MB-1:0] : e_sub[MB-1:0];
									eq_q <= {eq_q[MB-2:0], ~e_sub[MB]};
									ea_q <= ea_q << 1;
									ecnt_q <= ecnt_q - 7'd1;
								end else begin
									// q*v by shift-add over the quotient bits
									qv_q <= '0; vs_q <= ev_q;
									ecnt_q <= 7'(MB);
									ephase_q <= 2'd2;
								end
							end
							2'd2: begin
								if (ecnt_q != 7'd0) begin
									if (eq_q[0]) qv_q <= qv_q + vs_q;
									vs_q <= vs_q << 1;
									eq_q <= eq_q >> 1;
									ecnt_q <= ecnt_q - 7'd1;
								end else begin
									ea_q <= eb_q; eb_q <= er_q;
									eu_q <= ev_q; ev_q <= eu_q - qv_q;
									ephase_q <= 2'd0;
								end
							end
							default: ;
						endcase
					end
					default: ;
				endcase
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/core/mau_ctrl.sv -----
// Controller: sequences one item through the datapath and holds the result.
`timescale 1ns / 1ps
`default_nettype none
module mau_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  mau_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  wire                 out_ready,
	output mau_pkg::out_item_t  out_item,
	input  mau_pkg::stat_t      stat,
	input  wire [61:0]          res,
	output mau_pkg::ctrl_t      ctrl,
	output logic [5:0]          exp_idx
);
	mau_pkg::state_t state_q, state_d;
	mau_pkg::opcode_t op_q;
	logic err_q;
	logic [5:0] idx_q, idx_d;
	logic out_valid_q;
	logic [61:0] res_q;
	logic out_err_q;

	assign in_ready = (state_q == mau_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item.result = res_q;
	assign out_item.error = out_err_q;
	assign exp_idx = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mau_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			out_err_q <= 1'b0;
			idx_q <= '0;
			err_q <= 1'b0;
			op_q <= mau_pkg::OP_REDUCE;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			if (in_valid && in_ready) op_q <= in_item.opcode;
			if (state_q == mau_pkg::ST_OUT && !(out_valid_q && !out_ready)) begin
				out_valid_q <= 1'b1;
				res_q <= (stat.mod_small || err_q) ? '0 : res;
				out_err_q <= err_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == mau_pkg::ST_DISPATCH)
				err_q <= (op_q == mau_pkg::OP_POW) && stat.exp_neg;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		ctrl.cmd = mau_pkg::CMD_NONE;
		case (state_q)
			mau_pkg::ST_IDLE: if (in_valid) begin
				ctrl.cmd = mau_pkg::CMD_LOAD;
				state_d = mau_pkg::ST_RED_A;
			end
			mau_pkg::ST_RED_A: if (!stat.busy) begin
				ctrl.cmd = mau_pkg::CMD_RED_B;
				state_d = mau_pkg::ST_RED_B;
			end
			mau_pkg::ST_RED_B: if (!stat.busy) state_d = mau_pkg::ST_DISPATCH;
			mau_pkg::ST_DISPATCH: begin
				state_d = mau_pkg::ST_WAIT;
				if (stat.mod_small) begin
					ctrl.cmd = mau_pkg::CMD_SET_ZERO;
				end else begin
					case (op_q)
						mau_pkg::OP_ADD: ctrl.cmd = mau_pkg::CMD_ADD;
						mau_pkg::OP_SUB: ctrl.cmd = mau_pkg::CMD_SUB;
						mau_pkg::OP_NEG: ctrl.cmd = mau_pkg::CMD_NEG;
						mau_pkg::OP_MUL: ctrl.cmd = mau_pkg::CMD_MUL_AB;
						mau_pkg::OP_INV: ctrl.cmd = mau_pkg::CMD_INV_A;
						mau_pkg::OP_DIV: begin
							ctrl.cmd = mau_pkg::CMD_INV_B;
							state_d = mau_pkg::ST_INV;
						end
						mau_pkg::OP_POW: begin
							ctrl.cmd = mau_pkg::CMD_SET_ONE;
							idx_d = 6'd62;
							state_d = stat.exp_neg ? mau_pkg::ST_WAIT : mau_pkg::ST_POW_SQ;
						end
						default: ctrl.cmd = mau_pkg::CMD_SET_A;
					endcase
				end
			end
			mau_pkg::ST_POW_SQ: if (!stat.busy) begin
				ctrl.cmd = mau_pkg::CMD_MUL_RR;
				state_d = mau_pkg::ST_POW_MUL;
			end
			mau_pkg::ST_POW_MUL: if (!stat.busy) begin
				if (stat.exp_bit) ctrl.cmd = mau_pkg::CMD_MUL_RA;
				if (idx_q == 6'd0) begin
					state_d = mau_pkg::ST_WAIT;
				end else begin
					idx_d = idx_q - 6'd1;
					state_d = mau_pkg::ST_POW_SQ;
				end
			end
			mau_pkg::ST_INV: if (!stat.busy) begin
				ctrl.cmd = mau_pkg::CMD_MUL_AI;
				state_d = mau_pkg::ST_WAIT;
			end
			mau_pkg::ST_WAIT: if (!stat.busy) state_d = mau_pkg::ST_OUT;
			mau_pkg::ST_OUT: if (!(out_valid_q && !out_ready)) state_d = mau_pkg::ST_IDLE;
			default: state_d = mau_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/core/modular_arithmetic_unit_top.sv -----
// Top level of the modular arithmetic unit.
// One item in flight at a time, plus one output register that holds a finished result
// while out_ready is low. Reduce, add, subtract and negate run two serial reductions of
// the 64-bit operands; multiply adds one bit-serial multiply, power up to 126 multiplies
// after the reductions, and inverse and divide a run of Euclid steps, each a serial
// divide and a serial quotient multiply. A held result stalls the next item only when
// that item reaches its own output step.
`timescale 1ns / 1ps
`default_nettype none
module modular_arithmetic_unit_top #(
	parameter int unsigned MODULUS_BITS = mau_pkg::MODULUS_BITS
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  mau_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output mau_pkg::out_item_t out_data,
	input  wire                cfg_we,
	input  wire [61:0]         cfg_wdata
);
	// keep only the low MODULUS_BITS bits of the modulus
	localparam logic [61:0] MOD_MASK = (62'd1 << MODULUS_BITS) - 62'd1;

	logic [61:0] modulus_q;
	mau_pkg::ctrl_t ctrl;
	mau_pkg::stat_t stat;
	logic [61:0] res;
	logic [5:0] exp_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) modulus_q <= mau_pkg::MODULUS_RESET & MOD_MASK;
		else if (cfg_we) modulus_q <= cfg_wdata & MOD_MASK;
	end

	mau_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_item(in_data), .out_valid, .out_ready,
		.out_item(out_data), .stat, .res, .ctrl, .exp_idx
	);

	mau_datapath #(.MODULUS_BITS(MODULUS_BITS)) u_dp (
		.clk, .arst_n, .ctrl, .item(in_data), .modulus(modulus_q), .exp_idx, .stat, .res
	);
endmodule
`default_nettype wire

// ----- rtl/core/mau_checker.sv -----
// Port-level checker for the modular arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "modular_arithmetic_unit_top_assert.svh"
module mau_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                in_valid,
	input wire                in_ready,
	input wire                out_valid,
	input wire                out_ready,
	input mau_pkg::out_item_t out_data
);
	`MAU_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`MAU_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && out_data.error, out_data.result == '0)
	`MAU_ASSERT_NXT(a_one_inflight, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule
bind modular_arithmetic_unit_top mau_checker u_mau_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire
